FILE: design/rlb_pkg.sv
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared codes, types and arithmetic helpers for the RGBW layer blender.
// ----------------------------------------------------------------------------
package rlb_pkg;

  localparam int NUM_CH = 4;
  localparam int NUM_STAGES = 8;

  localparam logic [4:0] MODE_TOP      = 5'd0;
  localparam logic [4:0] MODE_BOTTOM   = 5'd1;
  localparam logic [4:0] MODE_ADD      = 5'd2;
  localparam logic [4:0] MODE_SUB      = 5'd3;
  localparam logic [4:0] MODE_DIFF     = 5'd4;
  localparam logic [4:0] MODE_AVG      = 5'd5;
  localparam logic [4:0] MODE_MUL      = 5'd6;
  localparam logic [4:0] MODE_DIVIDE   = 5'd7;
  localparam logic [4:0] MODE_LIGHTEN  = 5'd8;
  localparam logic [4:0] MODE_DARKEN   = 5'd9;
  localparam logic [4:0] MODE_SCREEN   = 5'd10;
  localparam logic [4:0] MODE_OVERLAY  = 5'd11;
  localparam logic [4:0] MODE_HARD     = 5'd12;
  localparam logic [4:0] MODE_SOFT     = 5'd13;
  localparam logic [4:0] MODE_DODGE    = 5'd14;
  localparam logic [4:0] MODE_BURN     = 5'd15;
  localparam logic [4:0] MODE_STENCIL  = 5'd16;

  localparam logic [0:0] REG_BLEND_MODE = 1'd0;
  localparam logic [0:0] REG_OPACITY    = 1'd1;

  localparam logic [1:0] ADD_SUM = 2'd0;
  localparam logic [1:0] ADD_DIV = 2'd1;
  localparam logic [1:0] ADD_A   = 2'd2;
  localparam logic [1:0] ADD_B   = 2'd3;

  // ceil(2^32 / 255), exact reciprocal for 24-bit numerators
  localparam logic [24:0] RECIP_255 = 25'h1010102;

  typedef struct packed {
    logic [1:0] add_sel;
    logic       top_nz;
  } pix_ctl_t;

  typedef struct packed {
    logic [16:0] rem;
    logic        qbit;
  } div_res_t;

  // floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] tmp;
    tmp = x + {8'd0, x[16:8]} + 17'd1;
    return tmp[15:8];
  endfunction

  // one restoring division step at quotient bit sh
  function automatic div_res_t div_step(input logic [16:0] rem, input logic [8:0] den,
                                        input int sh);
    div_res_t    res;
    logic [16:0] dsh;
    dsh = 17'(den) << sh;
    if (rem >= dsh) begin
      res.rem  = rem - dsh;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: design/rlb_chan.sv
// ----------------------------------------------------------------------------
// rlb_chan
// One 8-bit channel: products, pipelined divider, mode select and fade.
// ----------------------------------------------------------------------------
module rlb_chan (
  input  logic                           clk,
  input  logic [rlb_pkg::NUM_STAGES-1:0] stage_en,
  input  logic [4:0]                     mode,
  input  logic [7:0]                     opacity,
  input  logic [7:0]                     a,
  input  logic [7:0]                     b,
  input  logic [8:0]                     add_sum,
  input  logic [8:0]                     add_max,
  input  rlb_pkg::pix_ctl_t              ctl,
  output logic [7:0]                     res
);
  import rlb_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] s;
    logic       dflag;
    pix_ctl_t   ctl;
  } carry_t;

  // stage 1
  carry_t      c1_r;
  logic [15:0] pab1_r, pinv1_r, sa1_r;
  logic [16:0] num1_r;
  logic [8:0]  den1_r;
  // stage 2..4
  carry_t      c2_r, c3_r, c4_r;
  logic [7:0]  mab2_r, mab3_r, mab4_r;
  logic [7:0]  minv2_r, minv3_r, minv4_r;
  logic [24:0] sn2_r;
  logic [16:0] s3_r;
  logic [7:0]  soft4_r;
  logic [16:0] rem2_r, rem3_r, rem4_r;
  logic [8:0]  den2_r, den3_r, den4_r;
  logic [7:0]  q2_r, q3_r, q4_r;
  // stage 5..7
  logic [7:0]  mix5_r, b5_r;
  logic [16:0] acc6_r;
  logic [7:0]  res7_r;

  logic [7:0]  dx, dy;
  logic [16:0] y255;
  logic [16:0] tt;
  logic [49:0] soft_prod;
  div_res_t    d7, d6, d5, d4, d3, d2, d1, d0;
  logic [7:0]  qf, dv, mix_nxt;

  always_comb begin
    unique case (mode)
      MODE_DODGE: begin dx = ~a; dy = b;  end
      MODE_BURN:  begin dx = a;  dy = ~b; end
      default:    begin dx = a;  dy = b;  end
    endcase
    y255 = 17'({dy, 8'd0}) - 17'(dy);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      c1_r.a     <= a;
      c1_r.b     <= b;
      c1_r.s     <= add_sum[7:0];
      c1_r.dflag <= dx > dy;
      c1_r.ctl   <= ctl;
      pab1_r     <= 16'(a) * 16'(b);
      pinv1_r    <= 16'(8'd255 - a) * 16'(8'd255 - b);
      sa1_r      <= 16'(a) * 16'(8'd255 - b);
      if (mode == MODE_ADD) begin
        num1_r <= 17'({add_sum, 8'd0}) - 17'(add_sum);
        den1_r <= add_max;
      end else begin
        num1_r <= y255;
        den1_r <= {1'b0, dx};
      end
    end
  end

  assign tt = 17'(17'({c1_r.b, 8'd0}) - 17'(c1_r.b)) + {sa1_r, 1'b0};
  assign d7 = div_step(num1_r, den1_r, 7);
  assign d6 = div_step(d7.rem, den1_r, 6);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      c2_r    <= c1_r;
      mab2_r  <= div255({1'b0, pab1_r});
      minv2_r <= div255({1'b0, pinv1_r});
      sn2_r   <= 25'(c1_r.b) * 25'(tt);
      rem2_r  <= d6.rem;
      den2_r  <= den1_r;
      q2_r    <= {d7.qbit, d6.qbit, 6'd0};
    end
  end

  assign soft_prod = 50'(sn2_r) * 50'(RECIP_255);
  assign d5 = div_step(rem2_r, den2_r, 5);
  assign d4 = div_step(d5.rem, den2_r, 4);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      c3_r    <= c2_r;
      mab3_r  <= mab2_r;
      minv3_r <= minv2_r;
      s3_r    <= soft_prod[48:32];
      rem3_r  <= d4.rem;
      den3_r  <= den2_r;
      q3_r    <= {q2_r[7:6], d5.qbit, d4.qbit, 4'd0};
    end
  end

  assign d3 = div_step(rem3_r, den3_r, 3);
  assign d2 = div_step(d3.rem, den3_r, 2);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      c4_r    <= c3_r;
      mab4_r  <= mab3_r;
      minv4_r <= minv3_r;
      soft4_r <= div255(s3_r);
      rem4_r  <= d2.rem;
      den4_r  <= den3_r;
      q4_r    <= {q3_r[7:4], d3.qbit, d2.qbit, 2'd0};
    end
  end

  assign d1 = div_step(rem4_r, den4_r, 1);
  assign d0 = div_step(d1.rem, den4_r, 0);
  assign qf = {q4_r[7:2], d1.qbit, d0.qbit};
  assign dv = c4_r.dflag ? qf : 8'd255;

  always_comb begin
    unique case (mode) inside
      MODE_TOP:     mix_nxt = c4_r.a;
      MODE_BOTTOM:  mix_nxt = c4_r.b;
      MODE_ADD: begin
        case (c4_r.ctl.add_sel)
          ADD_SUM: mix_nxt = c4_r.s;
          ADD_DIV: mix_nxt = qf;
          ADD_A:   mix_nxt = c4_r.a;
          default: mix_nxt = c4_r.b;
        endcase
      end
      MODE_SUB:     mix_nxt = (c4_r.b > c4_r.a) ? c4_r.b - c4_r.a : 8'd0;
      MODE_DIFF:    mix_nxt = (c4_r.b > c4_r.a) ? c4_r.b - c4_r.a : c4_r.a - c4_r.b;
      MODE_AVG:     mix_nxt = 8'((9'(c4_r.a) + 9'(c4_r.b)) >> 1);
      MODE_MUL:     mix_nxt = mab4_r;
      MODE_DIVIDE,
      MODE_DODGE:   mix_nxt = dv;
      MODE_BURN:    mix_nxt = 8'd255 - dv;
      MODE_LIGHTEN: mix_nxt = (c4_r.a > c4_r.b) ? c4_r.a : c4_r.b;
      MODE_DARKEN:  mix_nxt = (c4_r.a < c4_r.b) ? c4_r.a : c4_r.b;
      MODE_SCREEN:  mix_nxt = 8'd255 - minv4_r;
      MODE_OVERLAY: mix_nxt = c4_r.b[7] ? 8'd255 - {minv4_r[6:0], 1'b0}
                                        : {mab4_r[6:0], 1'b0};
      MODE_HARD:    mix_nxt = c4_r.a[7] ? 8'd255 - {minv4_r[6:0], 1'b0}
                                        : {mab4_r[6:0], 1'b0};
      MODE_SOFT:    mix_nxt = soft4_r;
      MODE_STENCIL: mix_nxt = c4_r.ctl.top_nz ? c4_r.a : c4_r.b;
      default:      mix_nxt = c4_r.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      mix5_r <= mix_nxt;
      b5_r   <= c4_r.b;
    end
    if (stage_en[6]) begin
      acc6_r <= 17'(16'(b5_r) * 16'(8'd255 - opacity)) + 17'(16'(mix5_r) * 16'(opacity))
                + 17'd127;
    end
    if (stage_en[7]) begin
      res7_r <= div255(acc6_r);
    end
  end

  assign res = res7_r;

endmodule

FILE: design/rgbw_layer_blend_core.sv
// ----------------------------------------------------------------------------
// rgbw_layer_blend_core
// Blends a top RGBW pixel over an under pixel by mode, then fades by opacity.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while out_tready stays high; the
// eight register stages advance independently, so bubbles close up
// under output backpressure.
// Division steps run two quotient bits per stage across four stages.
// Reset (rst_n low, synchronous) empties the pipeline, blend_mode to top,
// opacity to 255.
module rgbw_layer_blend_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // top_pixel[31:0], under_pixel[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // out_pixel[31:0]
);
  import rlb_pkg::*;

  logic [4:0]            blend_mode_r;
  logic [7:0]            opacity_r;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] en;
  logic [31:0]           top_r, under_r;
  logic [8:0]            sum [NUM_CH];
  logic [8:0]            max01, max23, max_all;
  pix_ctl_t              ctl;
  logic                  in_fire, out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= MODE_TOP;
      opacity_r    <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_MODE: blend_mode_r <= cfg_wdata[4:0];
        REG_OPACITY:    opacity_r    <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) valid_r[0] <= in_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_r   <= in_tdata[31:0];
      under_r <= in_tdata[63:32];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = 9'(top_r[8*i +: 8]) + 9'(under_r[8*i +: 8]);
    end
    max01   = (sum[0] > sum[1]) ? sum[0] : sum[1];
    max23   = (sum[2] > sum[3]) ? sum[2] : sum[3];
    max_all = (max01 > max23) ? max01 : max23;
    ctl.top_nz = top_r != 32'd0;
    if (top_r == 32'd0)        ctl.add_sel = ADD_B;
    else if (under_r == 32'd0) ctl.add_sel = ADD_A;
    else if (max_all[8])       ctl.add_sel = ADD_DIV;
    else                       ctl.add_sel = ADD_SUM;
  end

  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    rlb_chan u_chan (
      .clk      (clk),
      .stage_en (en),
      .mode     (blend_mode_r),
      .opacity  (opacity_r),
      .a        (top_r[8*i +: 8]),
      .b        (under_r[8*i +: 8]),
      .add_sum  (sum[i]),
      .add_max  (max_all),
      .ctl      (ctl),
      .res      (out_tdata[8*i +: 8])
    );
  end

  assign out_tvalid = valid_r[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&valid_r) && !out_tready |-> !in_tready)
    else $error("pipeline full under stall but input ready");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !in_fire |=> $countones(valid_r) == $past($countones(valid_r)) - 1)
    else $error("transaction count wrong after output");

  a_count_rise: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_fire |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("transaction count wrong after input");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgbw_layer_blend_core: directed table of pixel pairs
// over every blend mode and opacity extreme, then random pixels under several
// register settings, checked against a behavioral blend/fade predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlb_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYC  = 40;

  typedef struct {
    logic [4:0]  mode;
    logic [7:0]  opac;
    logic [31:0] top;
    logic [31:0] under;
    logic        known;
    logic [31:0] pix;
  } blend_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_BLEND_MODE;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic [4:0]  cur_mode;
  logic [7:0]  cur_opac;
  logic [31:0] pixel_q[$];
  int          n_err = 0;
  int          idle_cyc = 0;
  int          snd_idle = 9;
  int          rcv_idle = 63;

  always #1 clk = ~clk;

  rgbw_layer_blend_core DUT (.*);

  function automatic logic [7:0] mul_ch(int a, int b);
    return 8'((a * b) / 255);
  endfunction

  function automatic logic [7:0] div_ch(int a, int b);
    return a > b ? 8'((b * 255) / a) : 8'd255;
  endfunction

  function automatic logic [7:0] mix_ch(logic [4:0] m, int a, int b);
    case (m)
      MODE_SUB:     return b > a ? 8'(b - a) : 8'd0;
      MODE_DIFF:    return b > a ? 8'(b - a) : 8'(a - b);
      MODE_AVG:     return 8'((a + b) >> 1);
      MODE_MUL:     return mul_ch(a, b);
      MODE_DIVIDE:  return div_ch(a, b);
      MODE_LIGHTEN: return a > b ? 8'(a) : 8'(b);
      MODE_DARKEN:  return a < b ? 8'(a) : 8'(b);
      MODE_SCREEN:  return 8'(255 - mul_ch(255 - a, 255 - b));
      MODE_OVERLAY: return b < 128 ? 8'(2 * mul_ch(a, b)) : 8'(255 - 2 * mul_ch(255 - a, 255 - b));
      MODE_HARD:    return a < 128 ? 8'(2 * mul_ch(a, b)) : 8'(255 - 2 * mul_ch(255 - a, 255 - b));
      MODE_SOFT:    return 8'((b * (255 * b + 2 * a * (255 - b))) / 65025);
      MODE_DODGE:   return div_ch(255 - a, b);
      MODE_BURN:    return 8'(255 - div_ch(a, 255 - b));
      default:      return 8'(a);
    endcase
  endfunction

  function automatic logic [31:0] blend_pixel(logic [4:0] m, logic [7:0] op,
                                              logic [31:0] t, logic [31:0] u);
    logic [31:0] mx;
    int          s[4];
    int          mxs;
    mxs = 0;
    if (m == MODE_TOP) mx = t;
    else if (m == MODE_BOTTOM) mx = u;
    else if (m == MODE_STENCIL) mx = (t != 0) ? t : u;
    else if (m == MODE_ADD) begin
      if (t == 0) mx = u;
      else if (u == 0) mx = t;
      else begin
        for (int i = 0; i < 4; i++) begin
          s[i] = t[8*i +: 8] + u[8*i +: 8];
          if (s[i] > mxs) mxs = s[i];
        end
        for (int i = 0; i < 4; i++)
          mx[8*i +: 8] = 8'(mxs > 255 ? (s[i] * 255) / mxs : s[i]);
      end
    end else begin
      for (int i = 0; i < 4; i++) mx[8*i +: 8] = mix_ch(m, t[8*i +: 8], u[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++)
      blend_pixel[8*i +: 8] = 8'((int'(u[8*i +: 8]) * (255 - op) + int'(mx[8*i +: 8]) * op
                                  + 127) / 255);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("ERROR %s: got %08h expected %08h", what, got, exp_v);
    n_err++;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) report_mismatch("unexpected out_pixel", out_tdata, 'x);
      else begin
        logic [31:0] e;
        e = pixel_q.pop_front();
        if (out_tdata !== e) report_mismatch("out_pixel", out_tdata, e);
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_BLEND_MODE) cur_mode = val[4:0];
    else cur_opac = val;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic send_pixels(logic [31:0] t, logic [31:0] u, logic known, logic [31:0] pix);
    logic [31:0] exp_pix;
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {u, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_pix = known ? pix : blend_pixel(cur_mode, cur_opac, t, u);
    pixel_q = {pixel_q, exp_pix};
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {4{8'($urandom_range(255))}};
      default: return $urandom;
    endcase
  endfunction

  blend_row_t rows[] = '{
    '{MODE_TOP,     8'd255, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 32'h1234_5678},
    '{MODE_TOP,     8'd0,   32'hFFFF_FFFF, 32'h0102_0304, 1'b1, 32'h0102_0304},
    '{MODE_BOTTOM,  8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_ADD,     8'd255, 32'h0000_0000, 32'hA0B0_C0D0, 1'b1, 32'hA0B0_C0D0},
    '{MODE_ADD,     8'd255, 32'h1122_3344, 32'h0000_0000, 1'b1, 32'h1122_3344},
    '{MODE_ADD,     8'd255, 32'h1010_1010, 32'h0102_0304, 1'b1, 32'h1112_1314},
    '{MODE_ADD,     8'd255, 32'hFF80_4000, 32'hFF80_4001, 1'b0, 32'h0},
    '{MODE_SUB,     8'd255, 32'h00FF_1080, 32'hFF00_2080, 1'b1, 32'hFF00_1000},
    '{MODE_DIFF,    8'd255, 32'h00FF_1080, 32'hFF00_2080, 1'b1, 32'hFFFF_1000},
    '{MODE_AVG,     8'd255, 32'hFFFF_0001, 32'hFF00_0003, 1'b0, 32'h0},
    '{MODE_MUL,     8'd255, 32'hFF00_FF80, 32'hFFFF_0080, 1'b0, 32'h0},
    '{MODE_DIVIDE,  8'd255, 32'h0000_FF80, 32'h0000_0040, 1'b0, 32'h0},
    '{MODE_LIGHTEN, 8'd255, 32'h00FF_1080, 32'hFF00_2080, 1'b1, 32'hFFFF_2080},
    '{MODE_DARKEN,  8'd255, 32'h00FF_1080, 32'hFF00_2080, 1'b1, 32'h0000_1080},
    '{MODE_SCREEN,  8'd255, 32'h00FF_7F80, 32'hFF00_8080, 1'b0, 32'h0},
    '{MODE_OVERLAY, 8'd255, 32'h80FF_7F00, 32'h7F80_FF00, 1'b0, 32'h0},
    '{MODE_HARD,    8'd255, 32'h80FF_7F00, 32'h7F80_FF00, 1'b0, 32'h0},
    '{MODE_SOFT,    8'd255, 32'hFF00_80FF, 32'hFFFF_8000, 1'b0, 32'h0},
    '{MODE_DODGE,   8'd255, 32'hFF00_8010, 32'h00FF_40FF, 1'b0, 32'h0},
    '{MODE_BURN,    8'd255, 32'hFF00_8010, 32'h00FF_40FF, 1'b0, 32'h0},
    '{MODE_STENCIL, 8'd255, 32'h0000_0000, 32'h5566_7788, 1'b1, 32'h5566_7788},
    '{MODE_STENCIL, 8'd255, 32'h0000_0001, 32'h5566_7788, 1'b1, 32'h0000_0001},
    '{5'd31,        8'd255, 32'hCAFE_0042, 32'h1111_1111, 1'b1, 32'hCAFE_0042},
    '{MODE_AVG,     8'd128, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0}
  };

  initial begin
    cur_mode = MODE_TOP;
    cur_opac = 8'd255;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset values: top mode at full opacity
    send_pixels(32'hDEAD_BEEF, 32'h0123_4567, 1'b1, 32'hDEAD_BEEF);
    wait_quiet();
    for (int r = 0; r < rows.size(); r++) begin
      if (rows[r].mode != cur_mode || rows[r].opac != cur_opac) begin
        wait_quiet();
        write_reg(REG_BLEND_MODE, 8'(rows[r].mode));
        write_reg(REG_OPACITY, rows[r].opac);
      end
      send_pixels(rows[r].top, rows[r].under, rows[r].known, rows[r].pix);
    end
    for (int ph = 0; ph < 24; ph++) begin
      snd_idle = ph < 8 ? 9 : (ph < 16 ? 63 : 0);
      rcv_idle = ph < 8 ? 63 : (ph < 16 ? 9 : 0);
      wait_quiet();
      write_reg(REG_BLEND_MODE, 8'(ph == 23 ? 31 : (ph % 17 == 0 ? $urandom_range(31) : ph % 17)));
      case (ph % 4)
        0: write_reg(REG_OPACITY, 8'd255);
        1: write_reg(REG_OPACITY, 8'd0);
        default: write_reg(REG_OPACITY, 8'($urandom_range(255)));
      endcase
      for (int k = 0; k < 21; k++) send_pixels(rand_pixel(), rand_pixel(), 1'b0, '0);
    end
    wait_quiet();
    if (n_err == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
